@@ design/pvp_pkg.sv @@
`default_nettype none
package pvp_pkg;
    localparam int DEPTH_SHIFT_DEF = 9;
    localparam int COORD_W = 16;
    localparam int PROD_W = 32;
    localparam int QUO_W = 32;
    localparam int TDATA_IN_W = 48;
    localparam int TDATA_OUT_W = 48;
    localparam int ADDR_W = 5;

    localparam logic [ADDR_W-1:0] ADDR_TAN_H = 5'd0;
    localparam logic [ADDR_W-1:0] ADDR_TAN_V = 5'd4;
    localparam logic [ADDR_W-1:0] ADDR_CTR_X = 5'd8;
    localparam logic [ADDR_W-1:0] ADDR_CTR_Y = 5'd12;
    localparam logic [ADDR_W-1:0] ADDR_SCL_X = 5'd16;
    localparam logic [ADDR_W-1:0] ADDR_SCL_Y = 5'd20;

    // Per-lane divide state carried through the restoring divider stages.
    typedef struct packed {
        logic [QUO_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic [QUO_W-1:0] dvs;
        logic             neg;
    } div_lane_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               bypass;
        logic               zdiv;
        logic [9:0]         cx;
        logic [9:0]         cy;
    } side_t;
endpackage
`default_nettype wire

@@ design/perspective_vertex_project.sv @@
`default_nettype none
// Perspective projection of a camera-space vertex to screen coordinates.
// One vertex is accepted per cycle when the output side keeps up; each result
// passes down the pipeline in order: two stages form the products and
// denominators, 32 stages run a restoring divider pair (one quotient bit per
// stage for x and y), and two stages apply signs, offsets and the output
// register. A stall freezes every stage at once. s_tdata = {z, y, x} from bit
// 0; m_tdata = {depth_out, screen_y, screen_x}, m_tuser = zero_divisor.
// Registers: 0 tan_half_hfov, 4 tan_half_vfov, 8 screen_center_x,
// 12 screen_center_y, 16 screen_scale_x, 20 screen_scale_y.
module perspective_vertex_project #(
    parameter int DEPTH_SHIFT = pvp_pkg::DEPTH_SHIFT_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [pvp_pkg::TDATA_IN_W-1:0] s_tdata,  // vertex_x, vertex_y, vertex_z
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [pvp_pkg::TDATA_OUT_W-1:0]     m_tdata,  // screen_x, screen_y, depth_out
    output logic                                m_tuser,  // zero_divisor
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [pvp_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [31:0]                    pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    localparam int W = pvp_pkg::QUO_W;
    localparam int NS = W + 4;

    logic [14:0] tanh_reg, tanv_reg, sclx_reg, scly_reg;
    logic [9:0]  ctrx_reg, ctry_reg;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tanh_reg <= 15'd256;
            tanv_reg <= 15'd256;
            ctrx_reg <= 10'd80;
            ctry_reg <= 10'd50;
            sclx_reg <= 15'd80;
            scly_reg <= 15'd50;
        end
        else if (psel && penable && pwrite)
        begin
            unique case (paddr)
                pvp_pkg::ADDR_TAN_H: tanh_reg <= pwdata[14:0];
                pvp_pkg::ADDR_TAN_V: tanv_reg <= pwdata[14:0];
                pvp_pkg::ADDR_CTR_X: ctrx_reg <= pwdata[9:0];
                pvp_pkg::ADDR_CTR_Y: ctry_reg <= pwdata[9:0];
                pvp_pkg::ADDR_SCL_X: sclx_reg <= pwdata[14:0];
                pvp_pkg::ADDR_SCL_Y: scly_reg <= pwdata[14:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr)
            pvp_pkg::ADDR_TAN_H: prdata = {17'd0, tanh_reg};
            pvp_pkg::ADDR_TAN_V: prdata = {17'd0, tanv_reg};
            pvp_pkg::ADDR_CTR_X: prdata = {22'd0, ctrx_reg};
            pvp_pkg::ADDR_CTR_Y: prdata = {22'd0, ctry_reg};
            pvp_pkg::ADDR_SCL_X: prdata = {17'd0, sclx_reg};
            pvp_pkg::ADDR_SCL_Y: prdata = {17'd0, scly_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // Global stall: advance when output register is free or being drained.
    logic adv;
    logic [NS-1:0] vld_reg;
    assign adv = !m_tvalid || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NS-2:0], s_tvalid};
    end
    assign m_tvalid = vld_reg[NS-1];

    // Stage 0: products.
    logic signed [31:0] nx_reg, ny_reg, dx_reg, dy_reg;
    pvp_pkg::side_t sd0_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            nx_reg <= $signed(s_tdata[15:0]) * $signed({1'b0, sclx_reg});
            ny_reg <= $signed(s_tdata[31:16]) * $signed({1'b0, scly_reg});
            dx_reg <= $signed(s_tdata[47:32]) * $signed({1'b0, tanh_reg});
            dy_reg <= $signed(s_tdata[47:32]) * $signed({1'b0, tanv_reg});
            sd0_reg.x <= s_tdata[15:0];
            sd0_reg.y <= s_tdata[31:16];
            sd0_reg.z <= s_tdata[47:32];
            sd0_reg.bypass <= 1'b0;
            sd0_reg.zdiv <= 1'b0;
            sd0_reg.cx <= ctrx_reg;
            sd0_reg.cy <= ctry_reg;
        end
    end

    // Stage 1: shift denominators, take magnitudes, classify.
    logic signed [31:0] sdx, sdy;
    assign sdx = dx_reg >>> DEPTH_SHIFT;
    assign sdy = dy_reg >>> DEPTH_SHIFT;

    pvp_pkg::side_t sd1_in;
    always_comb
    begin
        sd1_in = sd0_reg;
        sd1_in.bypass = (sd0_reg.z == '0) || (sdx == 0) || (sdy == 0);
        sd1_in.zdiv = (sd0_reg.z != '0) && ((sdx == 0) || (sdy == 0));
    end

    pvp_pkg::div_lane_t lx [W+1];
    pvp_pkg::div_lane_t ly [W+1];
    pvp_pkg::side_t     sd [W+1];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            lx[0].rem <= '0;
            lx[0].quo <= nx_reg[31] ? 32'(-nx_reg) : nx_reg;
            lx[0].dvs <= sdx[31] ? 32'(-sdx) : sdx;
            lx[0].neg <= nx_reg[31] ^ sdx[31];
            ly[0].rem <= '0;
            ly[0].quo <= ny_reg[31] ? 32'(-ny_reg) : ny_reg;
            ly[0].dvs <= sdy[31] ? 32'(-sdy) : sdy;
            ly[0].neg <= ny_reg[31] ^ sdy[31];
            sd[0] <= sd1_in;
        end
    end

    // Restoring divide: one quotient bit per stage for each lane.
    for (genvar i = 0; i < W; i++)
    begin : g_div
        logic [W:0] trx, try_;
        pvp_pkg::div_lane_t nx_l, ny_l;
        always_comb
        begin
            trx = {lx[i].rem, lx[i].quo[W-1]} - {1'b0, lx[i].dvs};
            nx_l = lx[i];
            if (!trx[W])
            begin
                nx_l.rem = trx[W-1:0];
                nx_l.quo = {lx[i].quo[W-2:0], 1'b1};
            end
            else
            begin
                nx_l.rem = {lx[i].rem[W-2:0], lx[i].quo[W-1]};
                nx_l.quo = {lx[i].quo[W-2:0], 1'b0};
            end
            try_ = {ly[i].rem, ly[i].quo[W-1]} - {1'b0, ly[i].dvs};
            ny_l = ly[i];
            if (!try_[W])
            begin
                ny_l.rem = try_[W-1:0];
                ny_l.quo = {ly[i].quo[W-2:0], 1'b1};
            end
            else
            begin
                ny_l.rem = {ly[i].rem[W-2:0], ly[i].quo[W-1]};
                ny_l.quo = {ly[i].quo[W-2:0], 1'b0};
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                lx[i+1] <= nx_l;
                ly[i+1] <= ny_l;
                sd[i+1] <= sd[i];
            end
        end
    end

    // Signs, offsets, and output register.
    logic [15:0] qx_reg, qy_reg;
    pvp_pkg::side_t sdf_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            qx_reg <= lx[W].neg ? 16'(-lx[W].quo) : lx[W].quo[15:0];
            qy_reg <= ly[W].neg ? 16'(-ly[W].quo) : ly[W].quo[15:0];
            sdf_reg <= sd[W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            if (sdf_reg.bypass)
            begin
                m_tdata[15:0]  <= sdf_reg.x;
                m_tdata[31:16] <= sdf_reg.y;
            end
            else
            begin
                m_tdata[15:0]  <= {6'd0, sdf_reg.cx} + qx_reg;
                m_tdata[31:16] <= {6'd0, sdf_reg.cy} - qy_reg;
            end
            m_tdata[47:32] <= sdf_reg.z;
            m_tuser <= sdf_reg.zdiv;
        end
    end
endmodule
`default_nettype wire
